@@ src/palc_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette color encoder package
// Shared widths, bus access codes, the per-transaction struct and the
// color level helpers.
// ----------------------------------------------------------------------------
package palc_pkg;

    localparam int ADDR_W     = 9;
    localparam int DATA_W     = 8;
    localparam int FIELD_W    = 3;
    localparam int LEVEL_W    = 8;
    localparam int CLOCK_W    = 2;
    localparam int LEVEL_STEP = 36;
    localparam int ADDR_SPAN  = 512;

    // Bus access codes carried in the mode field.
    typedef enum logic [2:0] {
        MODE_CTRL_WR    = 3'd0,
        MODE_ADDR_LO_WR = 3'd1,
        MODE_ADDR_HI_WR = 3'd2,
        MODE_DATA_LO_WR = 3'd3,
        MODE_DATA_HI_WR = 3'd4,
        MODE_DATA_LO_RD = 3'd5,
        MODE_DATA_HI_RD = 3'd6
    } mode_t;

    // Dot clock codes.
    localparam logic [CLOCK_W-1:0] CLOCK_FASTEST = 2'd2;
    localparam logic [CLOCK_W-1:0] CLOCK_ALIAS   = 2'd3;

    // One accepted transaction as it leaves the register stage.
    typedef struct packed {
        mode_t               mode;
        logic [DATA_W-1:0]   data;
        logic [ADDR_W-1:0]   color_index;
        logic [CLOCK_W-1:0]  clock_select;
    } access_t;

    // Scale a 3-bit color field to an 8-bit level.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [FIELD_W-1:0] field);
        return LEVEL_W'(field) * LEVEL_W'(LEVEL_STEP);
    endfunction

    // Map the control byte's clock bits to a dot clock choice.
    function automatic logic [CLOCK_W-1:0] clock_of(input logic [CLOCK_W-1:0] bits);
        return (bits == CLOCK_ALIAS) ? CLOCK_FASTEST : bits;
    endfunction

endpackage

@@ src/palc_if.sv @@
// ----------------------------------------------------------------------------
// Palette color encoder channels
// Valid/ready channels for bus accesses and for their results.
// ----------------------------------------------------------------------------
interface palc_access_if
    import palc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [DATA_W-1:0] data;

    modport source (output valid, mode, data, input ready);
    modport sink   (input valid, mode, data, output ready);
endinterface

interface palc_result_if
    import palc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_data;
    logic [CLOCK_W-1:0] clock_select;
    logic               color_written;
    logic [ADDR_W-1:0]  color_index;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;

    modport source (output valid, read_data, clock_select, color_written, color_index,
                    red, green, blue, input ready);
    modport sink   (input valid, read_data, clock_select, color_written, color_index,
                    red, green, blue, output ready);
endinterface

@@ src/palc_regs.sv @@
// ----------------------------------------------------------------------------
// Palette color encoder address and control registers
// Holds the color address and dot clock choice, and describes each accepted
// transaction with the palette entry that it uses.
// ----------------------------------------------------------------------------
module palc_regs
    import palc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mode_t             mode,
    input  logic [DATA_W-1:0] data,
    output access_t           info
);

    // The address wraps at the palette size or at the address width.
    localparam int WRAP = (PALETTE_ENTRIES < ADDR_SPAN) ? PALETTE_ENTRIES : ADDR_SPAN;

    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CLOCK_W-1:0] clock_reg, clock_next;
    logic [ADDR_W:0]    addr_inc;

    // Reduce the address into the palette by descending shifted subtraction.
    function automatic logic [ADDR_W-1:0] wrap_index(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r = a;
        for (int k = ADDR_W - 2; k >= 0; k--)
        begin
            if ((PALETTE_ENTRIES << k) < ADDR_SPAN)
            begin
                if (r >= ADDR_W'(PALETTE_ENTRIES << k))
                begin
                    r = r - ADDR_W'(PALETTE_ENTRIES << k);
                end
            end
        end
        return r;
    endfunction

    assign addr_inc = {1'b0, addr_reg} + (ADDR_W+1)'(1);

    // Next address and clock choice for the access on the port.
    always_comb
    begin
        addr_next  = addr_reg;
        clock_next = clock_reg;
        case (mode)
            MODE_CTRL_WR:
            begin
                clock_next = clock_of(data[CLOCK_W-1:0]);
            end
            MODE_ADDR_LO_WR:
            begin
                addr_next = {addr_reg[ADDR_W-1], data};
            end
            MODE_ADDR_HI_WR:
            begin
                addr_next = {data[0], addr_reg[DATA_W-1:0]};
            end
            MODE_DATA_HI_WR, MODE_DATA_HI_RD:
            begin
                if (addr_inc >= (ADDR_W+1)'(WRAP))
                begin
                    addr_next = '0;
                end
                else
                begin
                    addr_next = addr_inc[ADDR_W-1:0];
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    // Transaction description handed to the RAM and result stage.
    always_comb
    begin
        info.mode         = mode;
        info.data         = data;
        info.color_index  = wrap_index(addr_reg);
        info.clock_select = clock_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            clock_reg <= '0;
        end
        else if (accept)
        begin
            addr_reg  <= addr_next;
            clock_reg <= clock_next;
        end
    end

endmodule

@@ src/palc_ram.sv @@
// ----------------------------------------------------------------------------
// Palette color encoder palette RAM
// The palette as two byte-wide memories, each written at one address and
// read at one address per cycle with registered read data.
// ----------------------------------------------------------------------------
module palc_ram
    import palc_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int IDX_W = 9
) (
    input  logic              clk,
    input  logic              accept,
    input  access_t           info,
    output logic [DATA_W-1:0] lo_rd,
    output logic [DATA_W-1:0] hi_rd
);

    logic [DATA_W-1:0] lo_mem [DEPTH];
    logic [DATA_W-1:0] hi_mem [DEPTH];
    logic [DATA_W-1:0] lo_rd_reg;
    logic [DATA_W-1:0] hi_rd_reg;
    logic [IDX_W-1:0]  idx;

    assign idx = info.color_index[IDX_W-1:0];

    // Low byte memory: written by low data writes, read on every transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (info.mode == MODE_DATA_LO_WR)
            begin
                lo_mem[idx] <= info.data;
            end
            lo_rd_reg <= lo_mem[idx];
        end
    end

    // High byte memory: written by high data writes, read on every transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (info.mode == MODE_DATA_HI_WR)
            begin
                hi_mem[idx] <= info.data;
            end
            hi_rd_reg <= hi_mem[idx];
        end
    end

    assign lo_rd = lo_rd_reg;
    assign hi_rd = hi_rd_reg;

endmodule

@@ src/palc_result.sv @@
// ----------------------------------------------------------------------------
// Palette color encoder result stage
// Holds the accepted transaction beside the RAM read data, forms the result
// and keeps it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module palc_result
    import palc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  access_t              info,
    input  logic [DATA_W-1:0]    lo_rd,
    input  logic [DATA_W-1:0]    hi_rd,
    output logic                 in_ready,
    palc_result_if.source        result
);

    logic               stage_valid_reg, stage_valid_next;
    access_t            stage_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic               stage_move;

    logic [DATA_W-1:0]  read_data_reg, read_data_next;
    logic [CLOCK_W-1:0] clock_select_reg;
    logic               color_written_reg, color_written_next;
    logic [ADDR_W-1:0]  color_index_reg, color_index_next;
    logic [LEVEL_W-1:0] red_reg, red_next;
    logic [LEVEL_W-1:0] green_reg, green_next;
    logic [LEVEL_W-1:0] blue_reg, blue_next;
    logic [2*DATA_W-1:0] word;

    // Handshake: the output register loads when empty or being taken.
    assign out_load   = !out_valid_reg || result.ready;
    assign stage_move = stage_valid_reg && out_load;
    assign in_ready   = !stage_valid_reg || out_load;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_move)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (stage_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Result fields from the held transaction and the palette bytes.
    always_comb
    begin
        word               = '0;
        read_data_next     = '0;
        color_written_next = 1'b0;
        case (stage_reg.mode)
            MODE_DATA_LO_WR:
            begin
                word               = {hi_rd, stage_reg.data};
                color_written_next = 1'b1;
            end
            MODE_DATA_HI_WR:
            begin
                word               = {stage_reg.data, lo_rd};
                color_written_next = 1'b1;
            end
            MODE_DATA_LO_RD:
            begin
                read_data_next = lo_rd;
            end
            MODE_DATA_HI_RD:
            begin
                read_data_next = hi_rd;
            end
            default:
            begin
                read_data_next = '0;
            end
        endcase
        color_index_next = color_written_next ? stage_reg.color_index : '0;
        red_next         = level_of(word[5:3]);
        green_next       = level_of(word[8:6]);
        blue_next        = level_of(word[2:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= info;
        end
        if (stage_move)
        begin
            read_data_reg     <= read_data_next;
            clock_select_reg  <= stage_reg.clock_select;
            color_written_reg <= color_written_next;
            color_index_reg   <= color_index_next;
            red_reg           <= red_next;
            green_reg         <= green_next;
            blue_reg          <= blue_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.read_data     = read_data_reg;
    assign result.clock_select  = clock_select_reg;
    assign result.color_written = color_written_reg;
    assign result.color_index   = color_index_reg;
    assign result.red           = red_reg;
    assign result.green         = green_reg;
    assign result.blue          = blue_reg;

    // A write result carries no read byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.color_written |-> result.read_data == '0)
        else $error("write result carries read data");

    // A result that wrote nothing reports no entry and no color.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.color_written |->
            result.color_index == '0 && result.red == '0 &&
            result.green == '0 && result.blue == '0)
        else $error("color fields set without a palette write");

    // Input is held off only while both stages are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stage_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    // A held transaction that cannot move stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !out_load |=> stage_valid_reg && $stable(stage_reg))
        else $error("held transaction lost or changed");

    // The fastest dot clock is the top choice.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.clock_select != CLOCK_ALIAS)
        else $error("invalid dot clock choice");

endmodule

@@ src/palette_color_encoder_registers.sv @@
// ----------------------------------------------------------------------------
// Palette color encoder registers
// Byte-wide bus register block in front of a palette RAM of 16-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   The access channel takes one bus transaction per cycle while its ready
//   is high: mode selects a control write, an address byte write, or a data
//   byte read or write, and data carries the written byte. Every transaction
//   returns exactly one result on the result channel with the read byte, the
//   current dot clock choice and, for data writes, the palette entry and its
//   RGB levels. A high data byte access advances the color address, wrapping
//   at the end of the palette.
//   The RAM read data and the accepted transaction are registered first,
//   and the result register loads from them once it is free. Throughput is
//   one transaction per cycle while the receiver takes results, set by the
//   single read and write port of each byte memory.
//   Reset clears the address and the dot clock choice; palette contents are
//   undefined until written. When the receiver stalls, one transaction waits
//   in the result register and one behind it; access ready then drops.
// ----------------------------------------------------------------------------
module palette_color_encoder_registers
    import palc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    palc_access_if.sink   access,
    palc_result_if.source result
);

    localparam int DEPTH = (PALETTE_ENTRIES < ADDR_SPAN) ? PALETTE_ENTRIES : ADDR_SPAN;
    localparam int IDX_W = $clog2(DEPTH);

    logic              accept;
    logic              in_ready;
    access_t           info;
    logic [DATA_W-1:0] lo_rd;
    logic [DATA_W-1:0] hi_rd;

    assign access.ready = in_ready;
    assign accept       = access.valid && in_ready;

    palc_regs #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .mode   (mode_t'(access.mode)),
        .data   (access.data),
        .info   (info)
    );

    palc_ram #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk    (clk),
        .accept (accept),
        .info   (info),
        .lo_rd  (lo_rd),
        .hi_rd  (hi_rd)
    );

    palc_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .info     (info),
        .lo_rd    (lo_rd),
        .hi_rd    (hi_rd),
        .in_ready (in_ready),
        .result   (result)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette color encoder register testbench
// Sends byte-wide bus transactions to the register block and checks every
// result against a cycle-free model of the palette, the color address and
// the dot clock choice. Palette bytes that have not been written yet are
// held as unknown, so any level that depends on them is left unchecked.
// ----------------------------------------------------------------------------
module tb_top;
    import palc_pkg::*;

    localparam int PALETTE_ENTRIES = 512;
    localparam int STIM_TARGET     = 1300;
    localparam int QUIET_FIRST     = 1000;
    localparam int QUIET_LAST      = 1400;
    localparam int HOLD_CYCLES     = 120;
    localparam int PRINT_CAP       = 200;

    // The mode field has one code that the block does not use.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]         mode;
        logic [DATA_W-1:0]  data;
    } bus_access_t;

    typedef struct {
        logic [DATA_W-1:0]  read_data;
        logic [CLOCK_W-1:0] clock_select;
        logic               color_written;
        logic [ADDR_W-1:0]  color_index;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } color_result_t;

    logic clk = 1'b0;
    logic rst_n;

    palc_access_if access_ch ();
    palc_result_if result_ch ();

    palette_color_encoder_registers #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access_ch),
        .result (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transaction queues and run bookkeeping.
    bus_access_t   pending_accesses[$];
    color_result_t expected_colors[$];
    int unsigned   stim_items      = 0;
    int unsigned   total_queued    = 0;
    int unsigned   accepted_count  = 0;
    int unsigned   mismatch_count  = 0;
    int unsigned   cycle_count     = 0;
    int unsigned   ready_hold_left = 0;
    logic          access_taken    = 1'b0;

    // Generator shadow: address and which palette bytes hold known data.
    logic [ADDR_W-1:0] gen_addr = '0;
    bit                lo_seen[PALETTE_ENTRIES];
    bit                hi_seen[PALETTE_ENTRIES];

    // Predictor state. Palette words start unknown, as in the block.
    logic [15:0]        palette_shadow[PALETTE_ENTRIES];
    logic [ADDR_W-1:0]  color_addr   = '0;
    logic [CLOCK_W-1:0] clock_choice = '0;

    function automatic logic [ADDR_W-1:0] next_address(logic [ADDR_W-1:0] addr);
        int unsigned nxt;
        nxt = int'(addr) + 1;
        if (nxt >= PALETTE_ENTRIES || nxt >= ADDR_SPAN)
            nxt = 0;
        return ADDR_W'(nxt);
    endfunction

    function automatic logic [LEVEL_W-1:0] color_level(logic [FIELD_W-1:0] field);
        return {{(LEVEL_W - FIELD_W){1'b0}}, field} * LEVEL_W'(LEVEL_STEP);
    endfunction

    // Queue one transaction. Reads of bytes never written turn into writes
    // of that byte, so undefined palette contents are never read back.
    function automatic void queue_access(logic [2:0] m, logic [DATA_W-1:0] d);
        bus_access_t       item;
        logic [ADDR_W-1:0] slot;
        slot = ADDR_W'(gen_addr % PALETTE_ENTRIES);
        if (m == MODE_DATA_LO_RD && !lo_seen[slot])
            m = MODE_DATA_LO_WR;
        if (m == MODE_DATA_HI_RD && !hi_seen[slot])
            m = MODE_DATA_HI_WR;
        item.mode = m;
        item.data = d;
        pending_accesses.push_back(item);
        if (m != MODE_UNUSED)
            stim_items++;
        case (m)
            MODE_ADDR_LO_WR: gen_addr[7:0] = d;
            MODE_ADDR_HI_WR: gen_addr[8] = d[0];
            MODE_DATA_LO_WR: lo_seen[slot] = 1'b1;
            MODE_DATA_HI_WR:
            begin
                hi_seen[slot] = 1'b1;
                gen_addr = next_address(gen_addr);
            end
            MODE_DATA_HI_RD: gen_addr = next_address(gen_addr);
            default: ;
        endcase
    endfunction

    // Advance the predicted state by one accepted transaction and return
    // the result it must produce.
    function automatic color_result_t predict_color(logic [2:0] m, logic [DATA_W-1:0] d);
        color_result_t     res;
        logic [ADDR_W-1:0] idx;
        logic [15:0]       word;
        res = '{default: '0};
        idx = ADDR_W'(color_addr % PALETTE_ENTRIES);
        case (m)
            MODE_CTRL_WR:
            begin
                clock_choice = (d[1:0] == CLOCK_ALIAS) ? CLOCK_FASTEST : d[1:0];
            end
            MODE_ADDR_LO_WR: color_addr[7:0] = d;
            MODE_ADDR_HI_WR: color_addr[8] = d[0];
            MODE_DATA_LO_WR: palette_shadow[idx][7:0] = d;
            MODE_DATA_HI_WR:
            begin
                palette_shadow[idx][15:8] = d;
                color_addr = next_address(color_addr);
            end
            MODE_DATA_LO_RD: res.read_data = palette_shadow[idx][7:0];
            MODE_DATA_HI_RD:
            begin
                res.read_data = palette_shadow[idx][15:8];
                color_addr = next_address(color_addr);
            end
            default: ;
        endcase
        if (m == MODE_DATA_LO_WR || m == MODE_DATA_HI_WR)
        begin
            word              = palette_shadow[idx];
            res.color_written = 1'b1;
            res.color_index   = idx;
            res.red           = color_level(word[5:3]);
            res.green         = color_level(word[8:6]);
            res.blue          = color_level(word[2:0]);
        end
        res.clock_select = clock_choice;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    // A level built from an unwritten byte is unknown and is not compared.
    task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
        if (!$isunknown(want) && got !== want)
            report_mismatch($sformatf("%s: expected %0d, got %0d", name, want, got));
    endtask

    // Both sides run without gaps inside the quiet window.
    function automatic bit take_break();
        if (cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST)
            return 1'b0;
        return $urandom_range(99) < 34;
    endfunction

    // Sample both channels, predict on each accepted access and compare
    // each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        color_result_t want;
        if (rst_n)
        begin
            cycle_count  <= cycle_count + 1;
            access_taken <= access_ch.valid && access_ch.ready;
            if (access_ch.valid && access_ch.ready)
            begin
                expected_colors.push_back(predict_color(access_ch.mode, access_ch.data));
                accepted_count++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_colors.size() == 0)
                    report_mismatch("result transaction with no access waiting");
                else
                begin
                    want = expected_colors.pop_front();
                    check_field("read_data", 9'(want.read_data), 9'(result_ch.read_data));
                    check_field("clock_select", 9'(want.clock_select),
                                9'(result_ch.clock_select));
                    check_field("color_written", 9'(want.color_written),
                                9'(result_ch.color_written));
                    check_field("color_index", want.color_index, result_ch.color_index);
                    check_field("red", 9'(want.red), 9'(result_ch.red));
                    check_field("green", 9'(want.green), 9'(result_ch.green));
                    check_field("blue", 9'(want.blue), 9'(result_ch.blue));
                end
            end
        end
    end

    // Access driver: holds each transaction until it is taken, with random gaps.
    always @(negedge clk)
    begin : drive_access
        bus_access_t item;
        if (rst_n && (!access_ch.valid || access_taken))
        begin
            if (pending_accesses.size() != 0 && !take_break())
            begin
                item = pending_accesses.pop_front();
                access_ch.valid <= 1'b1;
                access_ch.mode  <= item.mode;
                access_ch.data  <= item.data;
            end
            else
                access_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus two long hold-offs that back the
    // block up into its access channel.
    always @(negedge clk)
    begin : drive_result_ready
        if (rst_n)
        begin
            if (cycle_count == 500 || cycle_count == 1800)
                ready_hold_left = HOLD_CYCLES;
            if (ready_hold_left != 0)
            begin
                ready_hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !take_break();
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] last_base;
        logic [DATA_W-1:0] junk;
        int unsigned       pick;
        int unsigned       len;

        rst_n           = 1'b0;
        access_ch.valid = 1'b0;
        access_ch.mode  = MODE_CTRL_WR;
        access_ch.data  = '0;
        result_ch.ready = 1'b0;
        last_base       = '0;

        // Directed: every dot clock code, including the alias of 3.
        queue_access(MODE_CTRL_WR, 8'h00);
        queue_access(MODE_CTRL_WR, 8'h01);
        queue_access(MODE_CTRL_WR, 8'hFE);
        queue_access(MODE_CTRL_WR, 8'hFF);
        // Last entry: low byte alone leaves green unknown, high byte wraps.
        queue_access(MODE_ADDR_LO_WR, 8'hFF);
        queue_access(MODE_ADDR_HI_WR, 8'hFF);
        queue_access(MODE_DATA_LO_WR, 8'hFF);
        queue_access(MODE_DATA_HI_WR, 8'hFF);
        queue_access(MODE_ADDR_LO_WR, 8'hFF);
        queue_access(MODE_ADDR_HI_WR, 8'h01);
        queue_access(MODE_DATA_LO_RD, 8'h00);
        queue_access(MODE_DATA_HI_RD, 8'h00);
        // Entry 0 all zero, then a high byte alone on entry 1.
        queue_access(MODE_DATA_LO_WR, 8'h00);
        queue_access(MODE_DATA_HI_WR, 8'h00);
        queue_access(MODE_DATA_HI_WR, 8'hA5);
        // Address high write keeps only bit 0.
        queue_access(MODE_ADDR_LO_WR, 8'h00);
        queue_access(MODE_ADDR_HI_WR, 8'hFE);
        queue_access(MODE_DATA_LO_RD, 8'hFF);
        queue_access(MODE_DATA_HI_RD, 8'hFF);
        queue_access(MODE_DATA_LO_WR, 8'h5A);
        queue_access(MODE_DATA_HI_RD, 8'h00);
        queue_access(MODE_UNUSED, 8'hAA);
        queue_access(MODE_CTRL_WR, 8'h02);
        queue_access(MODE_CTRL_WR, 8'h00);

        // Random: mostly address setup followed by write or read-back bursts.
        while (stim_items < STIM_TARGET)
        begin
            pick = $urandom_range(99);
            junk = DATA_W'($urandom);
            if (pick < 35)
            begin
                base = ADDR_W'($urandom_range(PALETTE_ENTRIES - 1));
                if ($urandom_range(7) == 0)
                    base = ADDR_W'(PALETTE_ENTRIES - 1 - $urandom_range(3));
                queue_access(MODE_ADDR_LO_WR, base[7:0]);
                queue_access(MODE_ADDR_HI_WR, {junk[7:1], base[8]});
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    queue_access(MODE_DATA_LO_WR, DATA_W'($urandom));
                    queue_access(MODE_DATA_HI_WR, DATA_W'($urandom));
                end
                last_base = base;
            end
            else if (pick < 60)
            begin
                queue_access(MODE_ADDR_LO_WR, last_base[7:0]);
                queue_access(MODE_ADDR_HI_WR, {junk[7:1], last_base[8]});
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    queue_access(MODE_DATA_LO_RD, DATA_W'($urandom));
                    queue_access(MODE_DATA_HI_RD, DATA_W'($urandom));
                end
            end
            else if (pick < 72)
                queue_access(MODE_CTRL_WR, junk);
            else if (pick < 88)
                queue_access(3'($urandom_range(7)), junk);
            else
            begin
                // Broken sequences: half an address, lone data bytes.
                case ($urandom_range(2))
                    0:
                    begin
                        queue_access(MODE_ADDR_LO_WR, junk);
                        queue_access(MODE_DATA_LO_WR, DATA_W'($urandom));
                    end
                    1: queue_access(MODE_DATA_HI_WR, junk);
                    default:
                    begin
                        queue_access(MODE_DATA_LO_WR, junk);
                        queue_access(MODE_DATA_LO_RD, DATA_W'($urandom));
                    end
                endcase
            end
        end
        total_queued = pending_accesses.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_queued || expected_colors.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (expected_colors.size() != 0)
            report_mismatch("results still outstanding at end of run");

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
